FILE: hw/rtl/damped_feedback_delay_line_unit_assert.svh
// Assertion macros for the damped feedback delay line.
// Included by the top level; needs no other file.
`ifndef DAMPED_FEEDBACK_DELAY_LINE_UNIT_ASSERT_SVH
`define DAMPED_FEEDBACK_DELAY_LINE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define DFDL_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("damped feedback delay line: assertion failed");
`define DFDL_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("damped feedback delay line: assertion failed");
`else
`define DFDL_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define DFDL_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif
`endif

FILE: hw/rtl/dfdl_pkg.sv
// Package for the damped feedback delay line: register codes, configuration
// and control word types, and the microprogram. Depends on nothing.
`default_nettype none

package dfdl_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 20;
	localparam int LEN_W = 14;
	localparam int GAIN_W = 16;
	localparam int COEF_W = 20;
	localparam int COEF_FRAC = 18;
	localparam int GAIN_FRAC = 15;
	localparam int STEP_W = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DELAY_LENGTH = 3'd0,
		REG_FEEDBACK_GAIN = 3'd1,
		REG_COEF_B0 = 3'd2,
		REG_COEF_B1 = 3'd3,
		REG_COEF_B2 = 3'd4,
		REG_COEF_A1 = 3'd5,
		REG_COEF_A2 = 3'd6
	} cfg_idx_e;

	typedef struct packed {
		logic [LEN_W-1:0] delay_length;
		logic signed [GAIN_W-1:0] feedback_gain;
		logic signed [COEF_W-1:0] coef_b0;
		logic signed [COEF_W-1:0] coef_b1;
		logic signed [COEF_W-1:0] coef_b2;
		logic signed [COEF_W-1:0] coef_a1;
		logic signed [COEF_W-1:0] coef_a2;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		delay_length: 14'd4096,
		feedback_gain: 16'sd0,
		coef_b0: 20'sd262144,
		coef_b1: 20'sd0,
		coef_b2: 20'sd0,
		coef_a1: 20'sd0,
		coef_a2: 20'sd0
	};

	typedef enum logic [2:0] {
		CS_B0 = 3'd0,
		CS_B1 = 3'd1,
		CS_B2 = 3'd2,
		CS_A1 = 3'd3,
		CS_A2 = 3'd4,
		CS_GAIN = 3'd5
	} coef_sel_e;

	typedef enum logic [2:0] {
		OS_D_MEM = 3'd0,
		OS_X1 = 3'd1,
		OS_X2 = 3'd2,
		OS_Y1 = 3'd3,
		OS_Y2 = 3'd4,
		OS_Y_NEW = 3'd5
	} opnd_sel_e;

	typedef enum logic [1:0] {
		AO_NONE = 2'd0,
		AO_LOAD = 2'd1,
		AO_ADD = 2'd2,
		AO_SUB = 2'd3
	} acc_op_e;

	typedef enum logic [1:0] {
		HOLD_NONE = 2'd0,
		HOLD_INPUT = 2'd1,
		HOLD_OUTPUT = 2'd2
	} hold_e;

	typedef struct packed {
		logic accept;
		logic mem_rd;
		logic mul_en;
		coef_sel_e coef_sel;
		opnd_sel_e opnd_sel;
		logic latch_d;
		acc_op_e acc_op;
		logic latch_y;
		logic finish;
		hold_e hold;
		logic jump;
		logic [STEP_W-1:0] target;
	} ctrl_word_t;

	typedef struct packed {
		logic in_valid;
		logic out_busy;
	} seq_status_t;

	localparam logic [STEP_W-1:0] ST_IDLE = 4'd0;
	localparam logic [STEP_W-1:0] ST_MUL_B0 = 4'd1;
	localparam logic [STEP_W-1:0] ST_MUL_B1 = 4'd2;
	localparam logic [STEP_W-1:0] ST_MUL_B2 = 4'd3;
	localparam logic [STEP_W-1:0] ST_MUL_A1 = 4'd4;
	localparam logic [STEP_W-1:0] ST_MUL_A2 = 4'd5;
	localparam logic [STEP_W-1:0] ST_ACC_END = 4'd6;
	localparam logic [STEP_W-1:0] ST_ROUND_Y = 4'd7;
	localparam logic [STEP_W-1:0] ST_MUL_GAIN = 4'd8;
	localparam logic [STEP_W-1:0] ST_FINISH = 4'd9;

	function automatic ctrl_word_t ucode_rom(input logic [STEP_W-1:0] step);
		ctrl_word_t w;
		w = '0;
		w.coef_sel = CS_B0;
		w.opnd_sel = OS_D_MEM;
		w.acc_op = AO_NONE;
		w.hold = HOLD_NONE;
		w.target = ST_IDLE;
		case (step)
			ST_IDLE: begin
				w.accept = 1'b1;
				w.mem_rd = 1'b1;
				w.hold = HOLD_INPUT;
			end
			ST_MUL_B0: begin
				w.mul_en = 1'b1;
				w.latch_d = 1'b1;
			end
			ST_MUL_B1: begin
				w.mul_en = 1'b1;
				w.coef_sel = CS_B1;
				w.opnd_sel = OS_X1;
				w.acc_op = AO_LOAD;
			end
			ST_MUL_B2: begin
				w.mul_en = 1'b1;
				w.coef_sel = CS_B2;
				w.opnd_sel = OS_X2;
				w.acc_op = AO_ADD;
			end
			ST_MUL_A1: begin
				w.mul_en = 1'b1;
				w.coef_sel = CS_A1;
				w.opnd_sel = OS_Y1;
				w.acc_op = AO_ADD;
			end
			ST_MUL_A2: begin
				w.mul_en = 1'b1;
				w.coef_sel = CS_A2;
				w.opnd_sel = OS_Y2;
				w.acc_op = AO_SUB;
			end
			ST_ACC_END: begin
				w.acc_op = AO_SUB;
			end
			ST_ROUND_Y: begin
				w.latch_y = 1'b1;
			end
			ST_MUL_GAIN: begin
				w.mul_en = 1'b1;
				w.coef_sel = CS_GAIN;
				w.opnd_sel = OS_Y_NEW;
			end
			ST_FINISH: begin
				w.finish = 1'b1;
				w.hold = HOLD_OUTPUT;
				w.jump = 1'b1;
			end
			default: begin
				w.jump = 1'b1;
			end
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/dfdl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module dfdl_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 8192
) (
	input wire logic clk,
	input wire logic wr_en,
	input wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input wire logic [WIDTH-1:0] wr_data,
	input wire logic rd_en,
	input wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

FILE: hw/rtl/dfdl_useq.sv
// Microcode sequencer: step counter, control word lookup and hold or jump.
// Depends on dfdl_pkg.
`default_nettype none

module dfdl_useq
	import dfdl_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire seq_status_t status,
	output ctrl_word_t ctrl
);

	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] step_d;
	logic hold;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

	always_comb begin
		ctrl = ucode_rom(step_q);
		case (ctrl.hold)
			HOLD_INPUT: hold = !status.in_valid;
			HOLD_OUTPUT: hold = status.out_busy;
			default: hold = 1'b0;
		endcase
		if (hold) begin
			step_d = step_q;
		end else if (ctrl.jump) begin
			step_d = ctrl.target;
		end else begin
			step_d = step_q + STEP_W'(1);
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/dfdl_dpath.sv
// Datapath: shared multiplier, accumulator, rounding and saturation, filter
// history, write position, delay store and output register.
// Depends on dfdl_pkg and dfdl_ram.
`default_nettype none

module dfdl_dpath
	import dfdl_pkg::*;
#(
	parameter int DELAY_DEPTH = 8192,
	parameter int SAMPLE_BITS = 24
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire ctrl_word_t ctrl,
	input wire cfg_t cfg,
	input wire logic in_valid,
	input wire logic [SAMPLE_BITS-1:0] sample_in,
	input wire logic out_stall,
	output logic out_valid,
	output logic [SAMPLE_BITS-1:0] sample_out,
	output logic out_busy
);

	localparam int AW = $clog2(DELAY_DEPTH);
	localparam int SB = SAMPLE_BITS;
	localparam int PW = COEF_W + SB;
	localparam int ACC_W = PW + 3;
	localparam int YW = ACC_W - COEF_FRAC;
	localparam int FW = PW - GAIN_FRAC;
	localparam int SW = FW + 1;

	logic [AW-1:0] pos_q;
	logic [AW:0] fill_q;
	logic signed [SB-1:0] x_q, d_q, y_q;
	logic signed [SB-1:0] x1_q, x2_q, y1_q, y2_q;
	logic signed [PW-1:0] mul_s1;
	logic signed [ACC_W-1:0] acc_q;
	logic out_valid_q;
	logic [SB-1:0] sample_out_q;

	logic in_fire, fin_fire;
	logic [SB-1:0] rd_data;
	logic signed [SB-1:0] d_mem;
	logic signed [COEF_W-1:0] mul_a;
	logic signed [SB-1:0] mul_b;
	logic signed [ACC_W-1:0] mul_ext;
	logic signed [ACC_W-1:0] acc_rnd;
	logic signed [YW-1:0] y_sh;
	logic signed [SB-1:0] y_sat;
	logic signed [PW-1:0] fb_rnd;
	logic signed [FW-1:0] fb;
	logic signed [SW-1:0] sum;
	logic signed [SB-1:0] w_sat;
	logic [31:0] len_w, pos_inc;
	logic [AW-1:0] pos_next;

	assign in_fire = ctrl.accept && in_valid;
	assign out_busy = out_valid_q && out_stall;
	assign fin_fire = ctrl.finish && !out_busy;

	dfdl_ram #(
		.WIDTH(SB),
		.DEPTH(DELAY_DEPTH)
	) u_store (
		.clk(clk),
		.wr_en(fin_fire),
		.wr_addr(pos_q),
		.wr_data(w_sat),
		.rd_en(ctrl.mem_rd),
		.rd_addr(pos_q),
		.rd_data(rd_data)
	);

	always_comb begin
		// Entries at or beyond the fill count have not been written since reset.
		d_mem = ({1'b0, pos_q} < fill_q) ? $signed(rd_data) : '0;

		case (ctrl.coef_sel)
			CS_B1: mul_a = cfg.coef_b1;
			CS_B2: mul_a = cfg.coef_b2;
			CS_A1: mul_a = cfg.coef_a1;
			CS_A2: mul_a = cfg.coef_a2;
			CS_GAIN: mul_a = $signed({{(COEF_W-GAIN_W){cfg.feedback_gain[GAIN_W-1]}},
				cfg.feedback_gain});
			default: mul_a = cfg.coef_b0;
		endcase
		case (ctrl.opnd_sel)
			OS_X1: mul_b = x1_q;
			OS_X2: mul_b = x2_q;
			OS_Y1: mul_b = y1_q;
			OS_Y2: mul_b = y2_q;
			OS_Y_NEW: mul_b = y_q;
			default: mul_b = d_mem;
		endcase

		mul_ext = $signed({{(ACC_W-PW){mul_s1[PW-1]}}, mul_s1});

		acc_rnd = acc_q + (ACC_W'(1) <<< (COEF_FRAC - 1));
		y_sh = acc_rnd[ACC_W-1:COEF_FRAC];
		if (&y_sh[YW-1:SB-1] || !(|y_sh[YW-1:SB-1])) begin
			y_sat = y_sh[SB-1:0];
		end else begin
			y_sat = {y_sh[YW-1], {(SB-1){!y_sh[YW-1]}}};
		end

		fb_rnd = mul_s1 + (PW'(1) <<< (GAIN_FRAC - 1));
		fb = fb_rnd[PW-1:GAIN_FRAC];
		sum = $signed({{(SW-SB){x_q[SB-1]}}, x_q}) + $signed({fb[FW-1], fb});
		if (&sum[SW-1:SB-1] || !(|sum[SW-1:SB-1])) begin
			w_sat = sum[SB-1:0];
		end else begin
			w_sat = {sum[SW-1], {(SB-1){!sum[SW-1]}}};
		end

		len_w = 32'(cfg.delay_length);
		if (len_w == 32'd0) begin
			len_w = 32'd1;
		end
		if (len_w > 32'(DELAY_DEPTH)) begin
			len_w = 32'(DELAY_DEPTH);
		end
		pos_inc = 32'(pos_q) + 32'd1;
		pos_next = (pos_inc >= len_w) ? '0 : pos_inc[AW-1:0];
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			x_q <= sample_in;
		end
		if (ctrl.latch_d) begin
			d_q <= d_mem;
		end
		if (ctrl.mul_en) begin
			mul_s1 <= mul_a * mul_b;
		end
		case (ctrl.acc_op)
			AO_LOAD: acc_q <= mul_ext;
			AO_ADD: acc_q <= acc_q + mul_ext;
			AO_SUB: acc_q <= acc_q - mul_ext;
			default: acc_q <= acc_q;
		endcase
		if (ctrl.latch_y) begin
			y_q <= y_sat;
		end
		if (fin_fire) begin
			sample_out_q <= d_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			fill_q <= '0;
			x1_q <= '0;
			x2_q <= '0;
			y1_q <= '0;
			y2_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_fire) begin
				pos_q <= pos_next;
				if ({1'b0, pos_q} == fill_q) begin
					fill_q <= fill_q + (AW+1)'(1);
				end
				x2_q <= x1_q;
				x1_q <= d_q;
				y2_q <= y1_q;
				y1_q <= y_q;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign sample_out = sample_out_q;

endmodule

`default_nettype wire

FILE: hw/rtl/damped_feedback_delay_line_unit.sv
// Top level of the damped feedback delay line: configuration registers,
// sequencer and datapath. Depends on dfdl_pkg, dfdl_useq, dfdl_dpath and
// the assertion header.
//
// Input channel in_valid, in_stall, sample_in: one signed sample per transfer.
// Output channel out_valid, out_stall, sample_out: the delayed sample read
// from the store, one result transfer for every input transfer, in order.
// Configuration channel cfg_valid, cfg_ready, cfg_index, cfg_data: cfg_ready
// is always high; indices beyond the coefficient a2 are ignored. Write only
// while the block is idle.
// Each sample runs through a ten-step microprogram around one shared
// multiplier: the store read, five biquad products, the last accumulation,
// the rounding step, the feedback gain product and the write back. The
// result is loaded into the output register at the write back, and a new
// sample is taken only after that step is done.
// If the output register still holds an untaken result, the final step waits
// until the receiver lifts out_stall, and in_stall stays high meanwhile.
// Reset clears the filter history, the write position and out_valid; the
// delay store reads as zero until written, tracked by a fill count, so no
// clearing pass is needed and the block takes input right after reset.
`default_nettype none

`include "damped_feedback_delay_line_unit_assert.svh"

module damped_feedback_delay_line_unit
	import dfdl_pkg::*;
#(
	parameter int DELAY_DEPTH = 8192,
	parameter int SAMPLE_BITS = 24
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [SAMPLE_BITS-1:0] sample_in,
	output logic out_valid,
	input wire logic out_stall,
	output logic [SAMPLE_BITS-1:0] sample_out,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t cfg_q;
	ctrl_word_t ctrl;
	seq_status_t status;
	logic out_busy;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DELAY_LENGTH: cfg_q.delay_length <= cfg_data[LEN_W-1:0];
				REG_FEEDBACK_GAIN: cfg_q.feedback_gain <= cfg_data[GAIN_W-1:0];
				REG_COEF_B0: cfg_q.coef_b0 <= cfg_data[COEF_W-1:0];
				REG_COEF_B1: cfg_q.coef_b1 <= cfg_data[COEF_W-1:0];
				REG_COEF_B2: cfg_q.coef_b2 <= cfg_data[COEF_W-1:0];
				REG_COEF_A1: cfg_q.coef_a1 <= cfg_data[COEF_W-1:0];
				REG_COEF_A2: cfg_q.coef_a2 <= cfg_data[COEF_W-1:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	assign status.in_valid = in_valid;
	assign status.out_busy = out_busy;
	assign in_stall = !ctrl.accept;

	dfdl_useq u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.status(status),
		.ctrl(ctrl)
	);

	dfdl_dpath #(
		.DELAY_DEPTH(DELAY_DEPTH),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_dpath (
		.clk(clk),
		.arst_n(arst_n),
		.ctrl(ctrl),
		.cfg(cfg_q),
		.in_valid(in_valid),
		.sample_in(sample_in),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.sample_out(sample_out),
		.out_busy(out_busy)
	);

	`DFDL_ASSERT_NXT(a_accept_then_busy, clk, arst_n, in_valid && !in_stall, in_stall)
	`DFDL_ASSERT_NXT(a_finish_loads_output, clk, arst_n, ctrl.finish && !out_busy, out_valid)
	`DFDL_ASSERT_NXT(a_finish_waits, clk, arst_n, ctrl.finish && out_busy, ctrl.finish)
	`DFDL_ASSERT_IMP(a_no_accept_in_finish, clk, arst_n, ctrl.finish, in_stall)

endmodule

`default_nettype wire

FILE: tb/damped_feedback_delay_line_unit_tb.sv
// Self-checking testbench for the damped feedback delay line: a table of directed
// transfers, then random phases of configuration and samples, checked by table or predictor.
// Depends on dfdl_pkg and the damped_feedback_delay_line_unit RTL.
module damped_feedback_delay_line_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import dfdl_pkg::*;

	localparam int LINE_DEPTH = 8192;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam longint SAMPLE_MAX = 64'sd8388607;
	localparam longint SAMPLE_MIN = -64'sd8388608;

	typedef struct {
		bit is_cfg;
		logic [CFG_IDX_W-1:0] index;
		logic [CFG_DATA_W-1:0] data;
		logic [23:0] sample;
		bit typed;
		logic [23:0] want;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [23:0] sample_in;
	logic out_valid;
	logic out_stall;
	logic [23:0] sample_out;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	cfg_t shadow_cfg;
	logic signed [23:0] line_mem [0:LINE_DEPTH-1];
	int unsigned write_pos;
	longint in_hist [2];
	longint out_hist [2];

	logic [23:0] delayed_samples_due [$];
	stim_row_t directed_rows [$];
	int mismatch_count = 0;
	bit calm = 1'b0;
	bit want_hold = 1'b0;
	int hold_left = 0;

	damped_feedback_delay_line_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample_in(sample_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sample_out(sample_out),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic longint clamp_sample(input longint v);
		if (v > SAMPLE_MAX) return SAMPLE_MAX;
		if (v < SAMPLE_MIN) return SAMPLE_MIN;
		return v;
	endfunction

	function automatic longint coef_value(input logic [COEF_W-1:0] c);
		return longint'(signed'(c));
	endfunction

	function automatic logic [23:0] comb_filter_step(input logic [23:0] raw);
		int unsigned span;
		int unsigned pos;
		longint x;
		longint d;
		longint acc;
		longint y;
		longint fb;
		span = 32'(shadow_cfg.delay_length);
		if (span == 0) span = 1;
		if (span > LINE_DEPTH) span = LINE_DEPTH;
		pos = write_pos % LINE_DEPTH;
		x = longint'(signed'(raw));
		d = line_mem[pos];
		acc = coef_value(shadow_cfg.coef_b0) * d
			+ coef_value(shadow_cfg.coef_b1) * in_hist[0]
			+ coef_value(shadow_cfg.coef_b2) * in_hist[1]
			- coef_value(shadow_cfg.coef_a1) * out_hist[0]
			- coef_value(shadow_cfg.coef_a2) * out_hist[1];
		y = clamp_sample((acc + 64'sd131072) >>> 18);
		in_hist[1] = in_hist[0];
		in_hist[0] = d;
		out_hist[1] = out_hist[0];
		out_hist[0] = y;
		fb = (y * longint'(signed'(shadow_cfg.feedback_gain)) + 64'sd16384) >>> 15;
		line_mem[pos] = 24'(clamp_sample(x + fb));
		write_pos = (pos + 1 >= span) ? 0 : pos + 1;
		return d[23:0];
	endfunction

	function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] data);
		stim_row_t r;
		r = '{default: '0};
		r.is_cfg = 1'b1;
		r.index = index;
		r.data = data;
		return r;
	endfunction

	function automatic stim_row_t sample_row(input logic [23:0] s, input bit typed,
			input logic [23:0] want);
		stim_row_t r;
		r = '{default: '0};
		r.sample = s;
		r.typed = typed;
		r.want = want;
		return r;
	endfunction

	task automatic flag_mismatch(input string what, input logic [23:0] got,
			input logic [23:0] want);
		$display("%0t: %s: sample_out got %h, expected %h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	task automatic send_sample(input logic [23:0] s, input bit typed, input logic [23:0] want);
		logic [23:0] predicted;
		cfg_valid <= 1'b0;
		while (!calm && $urandom_range(0, 99) < 16) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		sample_in <= s;
		do @(posedge clk); while (in_stall);
		predicted = comb_filter_step(s);
		delayed_samples_due.push_back(typed ? want : predicted);
		@(negedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (index)
			REG_DELAY_LENGTH: shadow_cfg.delay_length = data[LEN_W-1:0];
			REG_FEEDBACK_GAIN: shadow_cfg.feedback_gain = data[GAIN_W-1:0];
			REG_COEF_B0: shadow_cfg.coef_b0 = data;
			REG_COEF_B1: shadow_cfg.coef_b1 = data;
			REG_COEF_B2: shadow_cfg.coef_b2 = data;
			REG_COEF_A1: shadow_cfg.coef_a1 = data;
			REG_COEF_A2: shadow_cfg.coef_a2 = data;
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		cfg_valid <= 1'b0;
		while (delayed_samples_due.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	function automatic logic [CFG_DATA_W-1:0] pick_coef(input int mode);
		int v;
		case (mode)
			0: v = $urandom;
			1: v = int'($urandom_range(0, 65535)) - 32768;
			default: begin
				case ($urandom_range(0, 2))
					0: v = 20'h80000;
					1: v = 20'h7FFFF;
					default: v = 0;
				endcase
			end
		endcase
		return v[CFG_DATA_W-1:0];
	endfunction

	always @(negedge clk) begin
		if (want_hold) begin
			want_hold = 1'b0;
			hold_left = 300;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !calm && $urandom_range(0, 99) < 16;
		end
	end

	always @(posedge clk) begin : result_check
		logic [23:0] want;
		if (arst_n && out_valid && !out_stall) begin
			if (delayed_samples_due.size() == 0) begin
				flag_mismatch("result with nothing outstanding", sample_out, 'x);
			end else begin
				want = delayed_samples_due.pop_front();
				if (sample_out !== want)
					flag_mismatch("wrong delayed sample", sample_out, want);
			end
		end
	end

	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : stimulus
		int random_sent;
		int phase_items;
		int mode;
		int v;
		logic [LEN_W-1:0] span;
		logic [23:0] s;
		in_valid = 1'b0;
		sample_in = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		arst_n = 1'b0;
		shadow_cfg = CFG_RESET;
		foreach (line_mem[i]) line_mem[i] = '0;
		write_pos = 0;
		in_hist = '{0, 0};
		out_hist = '{0, 0};

		// Gain is zero and b0 is unity after reset, so the store simply holds each sample.
		directed_rows.push_back(sample_row(24'h7FFFFF, 1'b1, 24'h000000));
		directed_rows.push_back(sample_row(24'h800000, 1'b1, 24'h000000));
		directed_rows.push_back(cfg_row(REG_DELAY_LENGTH, 20'h00000));
		directed_rows.push_back(sample_row(24'h123456, 1'b1, 24'h000000));
		directed_rows.push_back(sample_row(24'hFFFFFF, 1'b1, 24'h7FFFFF));
		directed_rows.push_back(sample_row(24'h000005, 1'b1, 24'hFFFFFF));
		directed_rows.push_back(sample_row(24'h000000, 1'b1, 24'h000005));
		directed_rows.push_back(cfg_row(REG_UNUSED, 20'hFFFFF));
		directed_rows.push_back(cfg_row(REG_DELAY_LENGTH, 20'hFC003));
		directed_rows.push_back(sample_row(24'h400000, 1'b1, 24'h000000));
		directed_rows.push_back(sample_row(24'h000001, 1'b1, 24'h800000));
		directed_rows.push_back(sample_row(24'h000002, 1'b1, 24'h123456));
		directed_rows.push_back(cfg_row(REG_FEEDBACK_GAIN, 20'h07FFF));
		directed_rows.push_back(cfg_row(REG_COEF_B0, 20'h80000));
		directed_rows.push_back(cfg_row(REG_COEF_B1, 20'h7FFFF));
		directed_rows.push_back(cfg_row(REG_COEF_B2, 20'h80000));
		directed_rows.push_back(cfg_row(REG_COEF_A1, 20'h7FFFF));
		directed_rows.push_back(cfg_row(REG_COEF_A2, 20'h80000));
		directed_rows.push_back(sample_row(24'h7FFFFF, 1'b0, '0));
		directed_rows.push_back(sample_row(24'h800000, 1'b0, '0));
		directed_rows.push_back(sample_row(24'h7FFFFF, 1'b0, '0));
		directed_rows.push_back(sample_row(24'h800000, 1'b0, '0));
		directed_rows.push_back(sample_row(24'h000001, 1'b0, '0));
		directed_rows.push_back(sample_row(24'hFFFFFF, 1'b0, '0));
		directed_rows.push_back(cfg_row(REG_FEEDBACK_GAIN, 20'hF8000));
		directed_rows.push_back(cfg_row(REG_DELAY_LENGTH, 20'h03FFF));
		directed_rows.push_back(sample_row(24'h2AAAAA, 1'b0, '0));
		directed_rows.push_back(sample_row(24'hD55555, 1'b0, '0));
		directed_rows.push_back(sample_row(24'h7FFFFF, 1'b0, '0));
		directed_rows.push_back(cfg_row(REG_DELAY_LENGTH, 20'h02000));
		directed_rows.push_back(sample_row(24'h800000, 1'b0, '0));
		directed_rows.push_back(sample_row(24'h0F0F0F, 1'b0, '0));

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_cfg) begin
				wait_idle();
				write_register(directed_rows[i].index, directed_rows[i].data);
			end else begin
				send_sample(directed_rows[i].sample, directed_rows[i].typed,
					directed_rows[i].want);
			end
		end

		random_sent = 0;
		while (random_sent < 1200) begin
			wait_idle();
			case ($urandom_range(0, 9))
				0: span = 14'd0;
				1: span = 14'd8192;
				2: span = 14'($urandom_range(8193, 16383));
				3: span = 14'($urandom_range(100, 8191));
				default: span = 14'($urandom_range(1, 48));
			endcase
			write_register(REG_DELAY_LENGTH, {6'($urandom_range(0, 63)), span});
			case ($urandom_range(0, 3))
				0: v = 32'h7FFF;
				1: v = 32'h8000;
				default: v = $urandom;
			endcase
			write_register(REG_FEEDBACK_GAIN, {4'($urandom_range(0, 15)), v[15:0]});
			mode = $urandom_range(0, 2);
			v = 262144 + int'($urandom_range(0, 65535)) - 32768;
			write_register(REG_COEF_B0, (mode == 1) ? v[CFG_DATA_W-1:0] : pick_coef(mode));
			write_register(REG_COEF_B1, pick_coef(mode));
			write_register(REG_COEF_B2, pick_coef(mode));
			write_register(REG_COEF_A1, pick_coef(mode));
			write_register(REG_COEF_A2, pick_coef(mode));
			if ($urandom_range(0, 3) == 0)
				write_register(REG_UNUSED, 20'($urandom));
			phase_items = $urandom_range(60, 180);
			if (phase_items > 1200 - random_sent)
				phase_items = 1200 - random_sent;
			repeat (phase_items) begin
				calm = random_sent >= 300 && random_sent < 500;
				if (random_sent == 700)
					want_hold = 1'b1;
				case ($urandom_range(0, 9))
					0: s = 24'h7FFFFF;
					1: s = 24'h800000;
					2: s = 24'(int'($urandom_range(0, 511)) - 256);
					default: s = 24'($urandom);
				endcase
				send_sample(s, 1'b0, '0);
				random_sent++;
			end
		end

		in_valid <= 1'b0;
		cfg_valid <= 1'b0;
		while (delayed_samples_due.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/dfdl_pkg.sv
hw/rtl/dfdl_ram.sv
hw/rtl/dfdl_useq.sv
hw/rtl/dfdl_dpath.sv
hw/rtl/damped_feedback_delay_line_unit.sv
tb/damped_feedback_delay_line_unit_tb.sv
